/* src/bia_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap ID allocator package
// Shared sizes, transfer types, opcodes and helper functions.
// ---------------------------------------------------------------------------
package bia_pkg;

    localparam int WORD_BITS  = 64;
    localparam int NUM_WORDS  = 64;
    localparam int INDEX_W    = 12;
    localparam int INDEX_SPAN = 1 << INDEX_W;
    localparam int CAPACITY   = WORD_BITS * NUM_WORDS;
    localparam int LIMIT      = (CAPACITY < INDEX_SPAN) ? CAPACITY : INDEX_SPAN;

    localparam int WORD_AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int PE_W    = (NUM_WORDS > WORD_BITS) ? NUM_WORDS : WORD_BITS;
    localparam int PE_AW   = $clog2(PE_W);
    localparam int POS_W   = 17;

    // Index split by reciprocal multiplication; the estimate is low by at most one.
    localparam int DIV_SH    = 16;
    localparam int DIV_RECIP = (1 << DIV_SH) / WORD_BITS;
    localparam int RECIP_W   = DIV_SH + 1;
    localparam int PROD_W    = INDEX_W + RECIP_W;

    localparam logic [1:0] OP_MARK  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [INDEX_W-1:0] index;
    } t_req;

    typedef struct packed {
        logic               was_set;
        logic [INDEX_W-1:0] granted_index;
        logic               status;
    } t_rsp;

    typedef struct packed {
        logic             found;
        logic [PE_AW-1:0] pos;
    } t_pe;

    // Bits of a word that belong to usable indices.
    function automatic logic [WORD_BITS-1:0] valid_mask(input logic [WORD_AW-1:0] w);
        logic [POS_W-1:0] first;
        logic [POS_W-1:0] count;
        logic [WORD_BITS-1:0] mask;
        first = POS_W'(w) * POS_W'(WORD_BITS);
        count = POS_W'(LIMIT) - first;
        if (first >= POS_W'(LIMIT)) begin
            mask = '0;
        end else if (count >= POS_W'(WORD_BITS)) begin
            mask = '1;
        end else begin
            mask = ~({WORD_BITS{1'b1}} << count[BIT_W-1:0]);
        end
        return mask;
    endfunction

    // Contents of a word that has not been written since reset.
    function automatic logic [WORD_BITS-1:0] reset_word(input logic [WORD_AW-1:0] w);
        return (w == '0) ? WORD_BITS'(1) : '0;
    endfunction

    function automatic logic [NUM_WORDS-1:0] reset_full();
        logic [NUM_WORDS-1:0] full;
        for (int w = 0; w < NUM_WORDS; w++) begin
            full[w] = &(reset_word(WORD_AW'(w)) | ~valid_mask(WORD_AW'(w)));
        end
        return full;
    endfunction

    // Lowest set bit of a vector.
    function automatic t_pe find_first(input logic [PE_W-1:0] v);
        t_pe res;
        res.found = |v;
        res.pos   = '0;
        for (int i = PE_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                res.pos = PE_AW'(i);
            end
        end
        return res;
    endfunction

endpackage

/* src/bia_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bitmap_id_allocator_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap ID allocator
// Mark, query and allocate-lowest-free over a bitmap of identifier indices.
// ---------------------------------------------------------------------------
//  Channel    Signals                    Direction  Transfer
//  request    start, busy, i_req         in         start high while busy low
//  result     o_valid, o_rsp             out        one cycle with o_valid high
//
//  An item passes the transfer, a decode state in which the shared priority
//  encoder scans the per-word full flags (or the index is split into word and
//  bit) and the bitmap RAM read is issued, and an access state in which the
//  same encoder picks the bit and mark or allocate writes the word back. The
//  result appears the cycle after decode or access, when the next start is taken.
//  Synchronous active-low reset; no clearing pass, unwritten words read as reset.
//  The receiver cannot stall; every result is presented exactly once.
// ---------------------------------------------------------------------------
module bitmap_id_allocator_top
    import bia_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECODE = 3'b010,
        S_ACCESS = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [1:0]           r_op;
    logic [INDEX_W-1:0]   r_idx;
    logic [WORD_AW-1:0]   r_word, n_word;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic [NUM_WORDS-1:0] r_full;
    logic [NUM_WORDS-1:0] r_wvalid;
    t_rsp                 r_rsp, n_rsp;
    logic                 r_valid, n_valid;

    logic                 accept;
    logic [PROD_W-1:0]    prod;
    logic [INDEX_W-1:0]   q_est;
    logic [INDEX_W:0]     rem_est;
    logic [INDEX_W-1:0]   q_word;
    logic [INDEX_W:0]     rem_bit;
    logic                 in_range;

    logic [NUM_WORDS-1:0] not_full;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] cur_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] new_word;
    logic [BIT_W-1:0]     sel_bit;
    logic [POS_W-1:0]     grant_pos;
    logic [PE_W-1:0]      pe_in;
    t_pe                  pe;

    logic                 ram_we;
    logic                 ram_re;
    logic [WORD_AW-1:0]   ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Word and bit of the requested index.
    always_comb begin
        prod    = PROD_W'(r_idx) * PROD_W'(DIV_RECIP);
        q_est   = prod[DIV_SH +: INDEX_W];
        rem_est = (INDEX_W + 1)'(r_idx) - (INDEX_W + 1)'(q_est * INDEX_W'(WORD_BITS));
        if (rem_est >= (INDEX_W + 1)'(WORD_BITS)) begin
            q_word  = q_est + INDEX_W'(1);
            rem_bit = rem_est - (INDEX_W + 1)'(WORD_BITS);
        end else begin
            q_word  = q_est;
            rem_bit = rem_est;
        end
        in_range = (POS_W'(r_idx) < POS_W'(LIMIT));
    end

    // The shared priority encoder: full flags while decoding, free bits on access.
    assign not_full  = ~r_full;
    assign cur_word  = r_wvalid[r_word] ? ram_rdata : reset_word(r_word);
    assign cur_mask  = valid_mask(r_word);
    assign free_bits = ~cur_word & cur_mask;
    assign pe_in     = (r_state == S_DECODE) ? PE_W'(not_full) : PE_W'(free_bits);
    assign pe        = find_first(pe_in);

    assign sel_bit   = (r_op == OP_ALLOC) ? pe.pos[BIT_W-1:0] : r_bit;
    assign new_word  = cur_word | (WORD_BITS'(1) << sel_bit);
    assign grant_pos = POS_W'(r_word) * POS_W'(WORD_BITS) + POS_W'(sel_bit);

    assign ram_re    = (r_state == S_DECODE);
    assign ram_raddr = (r_op == OP_ALLOC) ? pe.pos[WORD_AW-1:0] : q_word[WORD_AW-1:0];
    assign ram_we    = (r_state == S_ACCESS) && (r_op == OP_MARK || r_op == OP_ALLOC);

    always_comb begin
        n_state = r_state;
        n_word  = r_word;
        n_bit   = r_bit;
        n_rsp   = '0;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_op == OP_ALLOC) begin
                    if (pe.found) begin
                        n_word  = pe.pos[WORD_AW-1:0];
                        n_state = S_ACCESS;
                    end else begin
                        n_rsp.status = 1'b1;
                        n_valid      = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if ((r_op == OP_MARK || r_op == OP_QUERY) && in_range) begin
                    n_word  = q_word[WORD_AW-1:0];
                    n_bit   = rem_bit[BIT_W-1:0];
                    n_state = S_ACCESS;
                end else begin
                    // Out-of-range index or unused opcode: nothing changes.
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ACCESS: begin
                if (r_op == OP_QUERY) begin
                    n_rsp.was_set = cur_word[r_bit];
                end
                if (r_op == OP_ALLOC) begin
                    n_rsp.granted_index = grant_pos[INDEX_W-1:0];
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_full   <= reset_full();
            r_wvalid <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (ram_we) begin
                r_wvalid[r_word] <= 1'b1;
                r_full[r_word]   <= &(new_word | ~cur_mask);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req.opcode;
            r_idx <= i_req.index;
        end
        r_word <= n_word;
        r_bit  <= n_bit;
        r_rsp  <= n_rsp;
    end

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_word),
        .i_wdata (new_word),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // A word whose full flag was clear must still hold a free bit.
    a_alloc_finds_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACCESS && r_op == OP_ALLOC) |-> pe.found)
        else $error("allocate reached a word without a free bit");

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DECODE))
        else $error("accepted request did not enter decode");

    a_result_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_valid |-> (r_state == S_DECODE || r_state == S_ACCESS))
        else $error("result raised outside decode or access");

    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_wvalid[$past(r_word)])
        else $error("written word not marked valid");

endmodule
